[hdl/u8d_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types for the streaming UTF-8 decoder: result status codes, the
// result item, the decoder state and the decode step outcome.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int unsigned CpW      = 21;
  localparam int unsigned PartialW = 15;
  localparam int unsigned QDepth   = 2;

  typedef enum logic [1:0] {
    ST_CHAR = 2'd0,
    ST_ERR  = 2'd1,
    ST_END  = 2'd2
  } status_e;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    status_e        status;
    logic           last;
  } result_t;

  typedef struct packed {
    logic [1:0]          pending;
    logic [PartialW-1:0] partial;
  } dec_state_t;

  // Outcome of decoding one item: up to two results and the next state.
  typedef struct packed {
    logic [1:0] n_res;
    result_t    res0;
    result_t    res1;
    dec_state_t next;
  } step_t;

endpackage : u8d_pkg
`default_nettype wire

[hdl/u8d_decode.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_decode
// Combinational decode step: classifies one byte against the open sequence
// and yields up to two results plus the next decoder state.
// ----------------------------------------------------------------------------
module u8d_decode import u8d_pkg::*; (
  input  wire logic [7:0] data_byte_i,
  input  wire logic       end_of_text_i,
  input  wire dec_state_t state_i,
  output step_t           step_o
);

  // Handling of a byte with no sequence open.
  typedef struct packed {
    logic       emit;
    result_t    res;
    dec_state_t next;
  } start_t;

  function automatic start_t start_byte(input logic [7:0] b);
    start_t s;
    s.emit = 1'b1;
    s.res  = '{code_point: '0, status: ST_ERR, last: 1'b1};
    s.next = '0;
    if (!b[7]) begin
      s.res.code_point = {{(CpW-8){1'b0}}, b};
      s.res.status     = ST_CHAR;
    end else if (!b[6]) begin
      s.emit = 1'b1;
    end else if (!b[5]) begin
      s.emit = 1'b0;
      s.next = '{pending: 2'd1, partial: {{(PartialW-5){1'b0}}, b[4:0]}};
    end else if (!b[4]) begin
      s.emit = 1'b0;
      s.next = '{pending: 2'd2, partial: {{(PartialW-4){1'b0}}, b[3:0]}};
    end else if (!b[3]) begin
      s.emit = 1'b0;
      s.next = '{pending: 2'd3, partial: {{(PartialW-3){1'b0}}, b[2:0]}};
    end
    return s;
  endfunction

  start_t         st;
  logic [CpW-1:0] merged;
  logic [1:0]     pend_dec;

  assign st       = start_byte(data_byte_i);
  assign merged   = {state_i.partial, data_byte_i[5:0]};
  assign pend_dec = state_i.pending - 2'd1;

  always_comb begin
    step_o       = '0;
    step_o.res0  = '{code_point: '0, status: ST_ERR, last: 1'b1};
    step_o.res1  = '{code_point: '0, status: ST_ERR, last: 1'b1};
    step_o.next  = state_i;
    if (end_of_text_i) begin
      step_o.n_res       = 2'd1;
      step_o.res0.status = (state_i.pending != 2'd0) ? ST_ERR : ST_END;
      step_o.next        = '0;
    end else if (state_i.pending == 2'd0) begin
      step_o.n_res = {1'b0, st.emit};
      step_o.res0  = st.res;
      step_o.next  = st.next;
    end else if (!data_byte_i[7]) begin
      // ASCII inside a sequence: abandon it and drop the byte.
      step_o.n_res = 2'd1;
      step_o.next  = '0;
    end else if (data_byte_i[6]) begin
      // New start byte inside a sequence: error, then handle it afresh.
      step_o.n_res     = st.emit ? 2'd2 : 2'd1;
      step_o.res0.last = !st.emit;
      step_o.res1      = st.res;
      step_o.next      = st.next;
    end else begin
      step_o.next.pending = pend_dec;
      if (pend_dec == 2'd0) begin
        step_o.n_res           = 2'd1;
        step_o.res0.code_point = merged;
        step_o.res0.status     = ST_CHAR;
        step_o.next.partial    = '0;
      end else begin
        step_o.next.partial = merged[PartialW-1:0];
      end
    end
  end

endmodule : u8d_decode
`default_nettype wire

[hdl/u8d_out_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_out_queue
// Two-entry result register queue: takes up to two results per cycle and
// presents one at a time on the output side.
// ----------------------------------------------------------------------------
module u8d_out_queue import u8d_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [1:0] wr_n_i,
  input  wire result_t    wr0_i,
  input  wire result_t    wr1_i,
  input  wire logic       pop_i,
  output logic [1:0]      space_o,
  output logic            valid_o,
  output result_t         head_o
);

  result_t    ent_q [QDepth];
  result_t    ent_d [QDepth];
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] cnt_p;
  logic [1:0] slot;
  result_t    wr [QDepth];

  assign wr[0]   = wr0_i;
  assign wr[1]   = wr1_i;
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = ent_q[0];
  assign space_o = 2'd2 - cnt_q + {1'b0, pop_i};

  always_comb begin
    ent_d = ent_q;
    cnt_p = cnt_q - {1'b0, pop_i};
    slot  = '0;
    if (pop_i) begin
      ent_d[0] = ent_q[1];
    end
    for (int i = 0; i < QDepth; i++) begin
      if (wr_n_i > 2'(i)) begin
        slot            = cnt_p + 2'(i);
        ent_d[slot[0]]  = wr[i];
      end
    end
    cnt_d = cnt_p + wr_n_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule : u8d_out_queue
`default_nettype wire

[hdl/utf8_stream_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming UTF-8 decoder: one byte or end marker in, code points, errors
// and end status out.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel carries one request per text byte in s_tdata_i; a
// request with s_tuser_i high is an end-of-text marker and its data byte is
// ignored. The master channel returns results: the code point in
// m_tdata_o (zero unless the status is a character), the status in
// m_tuser_o (character, decoding error, end of text) and m_tlast_o on the
// last result that a request causes. A request may cause zero, one or two
// results; start bytes of multi-byte sequences cause none when no sequence is open.
// A request is registered in the input register and its results in the
// result queue; only the queue head is visible on the master channel.
// A request waits in the input register until the two-entry result queue
// has room for all of its results, so one request per cycle is sustained
// while each causes at most one result and the receiver is ready; the two
// results of one request come out one at a time. When the receiver stalls,
// the queue fills and s_tready_o drops; nothing is lost or repeated.
// Reset clears the input register, the result queue and the decoder state
// (no sequence open).
// ----------------------------------------------------------------------------
module utf8_stream_decoder import u8d_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Slave side.
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [7:0]  s_tdata_i,   // [7:0] data_byte
  input  wire logic        s_tuser_i,   // [0] end_of_text
  // Master side.
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [23:0]      m_tdata_o,   // [20:0] code_point, [23:21] zero
  output logic [1:0]       m_tuser_o,   // [1:0] status
  output logic             m_tlast_o
);

  // Input register.
  logic       in_valid_q, in_valid_d;
  logic [7:0] byte_q;
  logic       eot_q;

  // Decoder state, updated when a request leaves the input register.
  dec_state_t state_q, state_d;

  step_t      step;
  logic [1:0] space;
  logic       advance;
  logic       pop;
  logic       q_valid;
  result_t    head;

  u8d_decode u_decode (
    .data_byte_i   (byte_q),
    .end_of_text_i (eot_q),
    .state_i       (state_q),
    .step_o        (step)
  );

  // A buffered request moves on only if all its results fit in the queue.
  assign advance    = in_valid_q && (step.n_res <= space);
  assign s_tready_o = !in_valid_q || advance;
  assign pop        = q_valid && m_tready_i;

  always_comb begin
    in_valid_d = in_valid_q;
    state_d    = state_q;
    if (advance) begin
      in_valid_d = 1'b0;
      state_d    = step.next;
    end
    if (s_tvalid_i && s_tready_o) begin
      in_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      state_q    <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid_i && s_tready_o) begin
      byte_q <= s_tdata_i;
      eot_q  <= s_tuser_i;
    end
  end

  u8d_out_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_n_i  (advance ? step.n_res : 2'd0),
    .wr0_i   (step.res0),
    .wr1_i   (step.res1),
    .pop_i   (pop),
    .space_o (space),
    .valid_o (q_valid),
    .head_o  (head)
  );

  assign m_tvalid_o = q_valid;
  assign m_tdata_o  = {3'b000, head.code_point};
  assign m_tuser_o  = head.status;
  assign m_tlast_o  = head.last;

endmodule : utf8_stream_decoder
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming UTF-8 decoder. A directed table covers
// the byte classes, the longest sequences, errors inside sequences and end
// markers. Random text follows: mostly well-formed characters, with truncated
// sequences, raw bytes and end markers mixed in. Every request is run through
// an in-bench decoder, and each result must match the oldest expected one.
// ----------------------------------------------------------------------------
module tb_top;
  import u8d_pkg::*;

  localparam int unsigned RandItems  = 500;
  localparam int unsigned QuietFrom  = 420;   // no idling on either side after this
  localparam int unsigned CycleLimit = 200000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid_i;
  logic        s_tready_o;
  logic [7:0]  s_tdata_i;   // [7:0] data_byte
  logic        s_tuser_i;   // [0] end_of_text
  logic        m_tvalid_o;
  logic        m_tready_i;
  logic [23:0] m_tdata_o;   // [20:0] code_point, [23:21] zero
  logic [1:0]  m_tuser_o;   // [1:0] status
  logic        m_tlast_o;

  utf8_stream_decoder DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

  // One row of the directed table. Rows with typed set carry the single
  // result they must give; the others are checked against the bench decoder.
  typedef struct packed {
    logic [7:0]     data;
    logic           eot;
    logic           typed;
    logic [CpW-1:0] cp;
    status_e        st;
  } text_row_t;

  text_row_t dir_rows [$];

  // Bench copy of the decoder state.
  logic [1:0]          seq_left;
  logic [PartialW-1:0] seq_bits;

  result_t step_res [$];      // results of the request just decoded
  result_t due_results [$];   // results still to come from the block
  result_t head;

  int errors;
  int cycles;
  int sent;
  bit quiet;
  int stall_left;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: a run that stops making progress ends as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, due_results.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // A byte decoded with no sequence open. Returns 1 when it gives a result,
  // or 0 when it opens a new sequence.
  function automatic logic lead_byte(input logic [7:0] b, output result_t r);
    r.code_point = '0;
    r.status     = ST_ERR;
    r.last       = 1'b0;
    if (!b[7]) begin
      r.code_point = {13'd0, b};
      r.status     = ST_CHAR;
      return 1'b1;
    end
    // A continuation byte here is stray; 11111xxx never starts anything.
    if (!b[6] || (b[5] && b[4] && b[3])) return 1'b1;
    if (!b[5]) begin
      seq_bits = {10'd0, b[4:0]};
      seq_left = 2'd1;
    end else if (!b[4]) begin
      seq_bits = {11'd0, b[3:0]};
      seq_left = 2'd2;
    end else begin
      seq_bits = {12'd0, b[2:0]};
      seq_left = 2'd3;
    end
    return 1'b0;
  endfunction

  // Decodes one request into step_res and advances the bench state.
  task automatic decode_byte(input logic [7:0] b, input logic eot);
    result_t r0;
    result_t r1;
    int n;
    logic [CpW-1:0] acc;
    n = 0;
    r0.code_point = '0;
    r0.status     = ST_ERR;
    r0.last       = 1'b0;
    r1 = r0;
    step_res.delete();
    if (eot) begin
      r0.status = (seq_left != 2'd0) ? ST_ERR : ST_END;
      seq_left  = 2'd0;
      seq_bits  = '0;
      n = 1;
    end else if (seq_left == 2'd0) begin
      if (lead_byte(b, r0)) n = 1;
    end else if (!b[7]) begin
      // ASCII inside a sequence: the byte is dropped with the sequence.
      seq_left = 2'd0;
      seq_bits = '0;
      n = 1;
    end else if (b[6]) begin
      // A start byte inside a sequence ends it with an error and is then
      // taken again as the start of something new.
      seq_left = 2'd0;
      seq_bits = '0;
      n = 1;
      if (lead_byte(b, r1)) n = 2;
    end else begin
      acc      = {seq_bits, b[5:0]};
      seq_left = seq_left - 2'd1;
      if (seq_left == 2'd0) begin
        seq_bits      = '0;
        r0.code_point = acc;
        r0.status     = ST_CHAR;
        n = 1;
      end else begin
        seq_bits = acc[PartialW-1:0];
      end
    end
    if (n == 1) r0.last = 1'b1;
    if (n == 2) r1.last = 1'b1;
    if (n >= 1) step_res.push_back(r0);
    if (n == 2) step_res.push_back(r1);
  endtask

  // Offers one request, with an occasional idle burst in front of it, and
  // records its expected results once it is accepted.
  task automatic push_byte(input logic [7:0] b, input logic eot,
                           input logic typed, input result_t want);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      @(negedge clk_i);
      s_tvalid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= b;
    s_tuser_i  <= eot;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    decode_byte(b, eot);
    if (typed) begin
      due_results.push_back(want);
    end else begin
      foreach (step_res[i]) due_results.push_back(step_res[i]);
    end
    sent++;
  endtask

  task automatic push_text(input logic [7:0] b, input logic eot);
    result_t none;
    none = '0;
    push_byte(b, eot, 1'b0, none);
  endtask

  // Holds the sender back until every expected result has come out.
  task automatic drain();
    @(negedge clk_i);
    s_tvalid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic add_row(input logic [7:0] data, input logic eot, input logic typed,
                         input logic [CpW-1:0] cp, input status_e st);
    text_row_t row;
    row.data  = data;
    row.eot   = eot;
    row.typed = typed;
    row.cp    = cp;
    row.st    = st;
    dir_rows.push_back(row);
  endtask

  // A random character of 1 to 4 bytes; cut_to below the full length leaves
  // the sequence unfinished for the next byte to break.
  task automatic push_char(input int len, input int cut_to);
    logic [7:0] b;
    b = 8'($urandom);
    case (len)
      1: b = {1'b0, b[6:0]};
      2: b = {3'b110, b[4:0]};
      3: b = {4'b1110, b[3:0]};
      default: b = {5'b11110, b[2:0]};
    endcase
    push_text(b, 1'b0);
    for (int i = 1; i < cut_to; i++) begin
      b = 8'($urandom);
      push_text({2'b10, b[5:0]}, 1'b0);
    end
  endtask

  // Receiver: ready drops in random bursts until the quiet part.
  initial begin
    m_tready_i = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_tready_i <= 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        m_tready_i <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        m_tready_i <= 1'b1;
      end
    end
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, actual data=%h status=%0d last=%b",
                 $time, m_tdata_o, m_tuser_o, m_tlast_o);
        errors++;
      end else begin
        head = due_results.pop_front();
        if (m_tdata_o !== {3'b000, head.code_point} || m_tuser_o !== head.status ||
            m_tlast_o !== head.last) begin
          $display("%0t: mismatch, expected data=%h status=%0d last=%b, actual data=%h status=%0d last=%b",
                   $time, {3'b000, head.code_point}, head.status, head.last,
                   m_tdata_o, m_tuser_o, m_tlast_o);
          errors++;
        end
      end
    end
  end

  initial begin
    result_t want;
    int kind;
    int len;
    s_tvalid_i = 1'b0;
    s_tdata_i  = 8'h00;
    s_tuser_i  = 1'b0;
    rst_ni     = 1'b0;
    sent       = 0;
    quiet      = 1'b0;
    seq_left   = 2'd0;
    seq_bits   = '0;

    // End marker straight after reset, then the extremes of each byte class.
    add_row(8'h00, 1'b1, 1'b1, 21'h0,      ST_END);
    add_row(8'h00, 1'b0, 1'b1, 21'h0,      ST_CHAR);
    add_row(8'h7f, 1'b0, 1'b1, 21'h7f,     ST_CHAR);
    add_row(8'h80, 1'b0, 1'b1, 21'h0,      ST_ERR);   // stray continuation
    add_row(8'hbf, 1'b0, 1'b1, 21'h0,      ST_ERR);
    add_row(8'hf8, 1'b0, 1'b1, 21'h0,      ST_ERR);   // 11111xxx
    add_row(8'hff, 1'b0, 1'b1, 21'h0,      ST_ERR);
    // Two-, three- and four-byte characters, the last one the largest value.
    add_row(8'hc2, 1'b0, 1'b0, 21'h0,      ST_CHAR);
    add_row(8'ha9, 1'b0, 1'b0, 21'h0,      ST_CHAR);
    add_row(8'he2, 1'b0, 1'b0, 21'h0,      ST_CHAR);
    add_row(8'h82, 1'b0, 1'b0, 21'h0,      ST_CHAR);
    add_row(8'hac, 1'b0, 1'b0, 21'h0,      ST_CHAR);
    add_row(8'hf7, 1'b0, 1'b0, 21'h0,      ST_CHAR);
    add_row(8'hbf, 1'b0, 1'b0, 21'h0,      ST_CHAR);
    add_row(8'hbf, 1'b0, 1'b0, 21'h0,      ST_CHAR);
    add_row(8'hbf, 1'b0, 1'b0, 21'h0,      ST_CHAR);
    // ASCII inside a sequence is dropped with an error.
    add_row(8'hc3, 1'b0, 1'b0, 21'h0,      ST_CHAR);
    add_row(8'h41, 1'b0, 1'b1, 21'h0,      ST_ERR);
    // Start byte inside a sequence reopens; then one that cannot start.
    add_row(8'he0, 1'b0, 1'b0, 21'h0,      ST_CHAR);
    add_row(8'hc5, 1'b0, 1'b0, 21'h0,      ST_CHAR);
    add_row(8'h80, 1'b0, 1'b0, 21'h0,      ST_CHAR);
    add_row(8'hc0, 1'b0, 1'b0, 21'h0,      ST_CHAR);
    add_row(8'hff, 1'b0, 1'b0, 21'h0,      ST_CHAR);
    // End marker inside a sequence, and the clean one after it.
    add_row(8'hf0, 1'b0, 1'b0, 21'h0,      ST_CHAR);
    add_row(8'haa, 1'b1, 1'b1, 21'h0,      ST_ERR);
    add_row(8'h55, 1'b1, 1'b1, 21'h0,      ST_END);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      want.code_point = dir_rows[i].cp;
      want.status     = dir_rows[i].st;
      want.last       = 1'b1;
      push_byte(dir_rows[i].data, dir_rows[i].eot, dir_rows[i].typed, want);
    end
    drain();

    // Random text: mostly whole characters, some cut short, some noise.
    sent = 0;
    while (sent < RandItems) begin
      if (sent >= RandItems / 2 && sent < RandItems / 2 + 4) drain();
      if (sent >= QuietFrom) quiet = 1'b1;
      kind = $urandom_range(0, 9);
      len  = $urandom_range(1, 4);
      if (kind <= 6) begin
        push_char(len, len);
      end else if (kind == 7) begin
        len = $urandom_range(2, 4);
        push_char(len, $urandom_range(1, len - 1));
      end else if (kind == 8) begin
        push_text(8'($urandom), 1'b0);
      end else begin
        push_text(8'($urandom), 1'b1);
      end
    end

    @(negedge clk_i);
    s_tvalid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    // Waiting on afterwards catches any result the block adds unasked.
    repeat (8) @(posedge clk_i);

    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule : tb_top
